[rtl/gec_pkg.sv]
package gec_pkg;

  localparam int NODE_W        = 12;
  localparam int COLOR_FIELD_W = 5;
  localparam int RANK_W        = 16;
  localparam int COUNT_W       = 17;
  localparam int COUNT_CAP     = (1 << COUNT_W) - 1;
  localparam int RANK_CAP      = (1 << RANK_W) - 1;

  typedef struct packed {
    logic [NODE_W-1:0] start_node;
    logic [NODE_W-1:0] end_node;
  } gec_in_t;

  typedef struct packed {
    logic [COLOR_FIELD_W-1:0] color;
    logic [RANK_W-1:0]        rank_in_color;
    logic                     overflow;
  } gec_out_t;

endpackage

[rtl/gec_node_ram.sv]
module gec_node_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b,
  input  logic              we_a,
  input  logic [ADDR_W-1:0] wr_addr_a,
  input  logic [DATA_W-1:0] wr_data_a,
  input  logic              we_b,
  input  logic [ADDR_W-1:0] wr_addr_b,
  input  logic [DATA_W-1:0] wr_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // read-before-write on an address collision; caller forwards
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem[wr_addr_a] <= wr_data_a;
    end
    if (we_b) begin
      mem[wr_addr_b] <= wr_data_b;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[rtl/gec_count_ram.sv]
module gec_count_ram
  import gec_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [COUNT_W-1:0] rd_data,
  input  logic               we,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [COUNT_W-1:0] wr_data
);

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   filled;
  logic               rd_filled;
  logic [COUNT_W-1:0] rd_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (we) begin
      filled[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw    <= mem[rd_addr];
      rd_filled <= filled[rd_addr];
    end
  end

  // entries never written read as zero
  assign rd_data = rd_filled ? rd_raw : '0;

endmodule

[rtl/gec_color_pick.sv]
module gec_color_pick #(
  parameter int COLOR_COUNT = 32,
  parameter int IDX_W       = 5
) (
  input  logic [COLOR_COUNT-1:0] used_a,
  input  logic [COLOR_COUNT-1:0] used_b,
  output logic [COLOR_COUNT-1:0] pick_bit,
  output logic [IDX_W-1:0]       pick_idx,
  output logic                   none_free
);

  logic [COLOR_COUNT-1:0] free;

  assign free      = ~(used_a | used_b);
  // isolate lowest free color
  assign pick_bit  = free & (~free + COLOR_COUNT'(1));
  assign none_free = (free == '0);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < COLOR_COUNT; i++) begin
      if (pick_bit[i]) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
    end
  end

endmodule

[rtl/greedy_edge_color_assigner.sv]
// Greedy edge colorer: one edge beat in, one result beat out, in order. Sustained
// throughput is one edge per clock while out_ready stays high; a result is registered
// through stage 1, stage 2 and the output register. The rate is set by the node mask
// memory, which does two reads and two writes each cycle, with the last write
// forwarded to the next edge's masks; the color count memory sits one stage later
// with its own write forwarding. After reset the mask memory is swept to zero,
// one entry per cycle, over min(NODE_COUNT, 4096) entries (4096 by default)
// while in_ready stays low. An endpoint index at or above NODE_COUNT, or no free
// color, gives overflow with color and rank zero and leaves all state unchanged.
module greedy_edge_color_assigner
  import gec_pkg::*;
#(
  parameter int NODE_COUNT  = 4096,
  parameter int COLOR_COUNT = 32,
  parameter int EDGE_LIMIT  = 65536
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  gec_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output gec_out_t out_data
);

  localparam int NODE_SPAN = 1 << NODE_W;
  localparam int MEM_DEPTH = (NODE_COUNT < NODE_SPAN) ? NODE_COUNT : NODE_SPAN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int IDX_W     = $clog2(COLOR_COUNT);
  localparam int CNT_LIMIT = (EDGE_LIMIT > COUNT_CAP) ? COUNT_CAP : EDGE_LIMIT;
  localparam logic [COUNT_W-1:0] LIMIT_V   = COUNT_W'(CNT_LIMIT);
  localparam logic [COUNT_W-1:0] RANK_TOP  = COUNT_W'(RANK_CAP);
  localparam logic [ADDR_W-1:0]  CLR_LAST  = ADDR_W'(MEM_DEPTH - 1);

  // clearing sweep
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // handshake
  logic in_fire, s1_fire, s2_fire, adv1, adv2;

  // stage 1: masks back from memory
  logic              s1_valid, s1_bad;
  logic [ADDR_W-1:0] s1_a, s1_b;
  logic [COLOR_COUNT-1:0] rd_a, rd_b, used_a, used_b, pick_bit;
  logic [IDX_W-1:0]       pick_idx;
  logic                   none_free, s1_ovf, node_we;
  logic                   in_bad;

  // last mask write, forwarded into stage 1
  logic                   fw_valid;
  logic [ADDR_W-1:0]      fw_a, fw_b;
  logic [COLOR_COUNT-1:0] fw_bit;

  // stage 2: color count
  logic               s2_valid, s2_ovf;
  logic [IDX_W-1:0]   s2_color;
  logic [COUNT_W-1:0] cnt_rd, cnt_cur, cnt_next;
  logic [RANK_W-1:0]  rank;
  logic               count_we;
  logic               cfw_valid;
  logic [IDX_W-1:0]   cfw_addr;
  logic [COUNT_W-1:0] cfw_data;

  logic                   mem_we_a;
  logic [ADDR_W-1:0]      mem_addr_a;
  logic [COLOR_COUNT-1:0] mem_data_a;

  assign adv2     = !out_valid || out_ready;
  assign s2_fire  = s2_valid && adv2;
  assign adv1     = !s2_valid || adv2;
  assign s1_fire  = s1_valid && adv1;
  assign in_ready = !clearing && (!s1_valid || adv1);
  assign in_fire  = in_valid && in_ready;

  assign in_bad = ({20'd0, in_data.start_node} >= 32'(NODE_COUNT)) ||
                  ({20'd0, in_data.end_node} >= 32'(NODE_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // masks of the edge in stage 1, with the previous edge's update folded in
  always_comb begin
    used_a = rd_a;
    used_b = rd_b;
    if (fw_valid && (fw_a == s1_a || fw_b == s1_a)) begin
      used_a = rd_a | fw_bit;
    end
    if (fw_valid && (fw_a == s1_b || fw_b == s1_b)) begin
      used_b = rd_b | fw_bit;
    end
  end

  gec_color_pick #(
    .COLOR_COUNT (COLOR_COUNT),
    .IDX_W       (IDX_W)
  ) u_pick (
    .used_a    (used_a),
    .used_b    (used_b),
    .pick_bit  (pick_bit),
    .pick_idx  (pick_idx),
    .none_free (none_free)
  );

  assign s1_ovf  = s1_bad || none_free;
  assign node_we = s1_fire && !s1_ovf;

  assign mem_we_a   = clearing || node_we;
  assign mem_addr_a = clearing ? clr_addr : s1_a;
  assign mem_data_a = clearing ? '0 : (used_a | pick_bit);

  // a self-loop writes its one mask through port a only
  gec_node_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (COLOR_COUNT)
  ) u_node_ram (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr_a (ADDR_W'(in_data.start_node)),
    .rd_addr_b (ADDR_W'(in_data.end_node)),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .we_a      (mem_we_a),
    .wr_addr_a (mem_addr_a),
    .wr_data_a (mem_data_a),
    .we_b      (node_we && (s1_b != s1_a)),
    .wr_addr_b (s1_b),
    .wr_data_b (used_b | pick_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_fire) begin
      s1_bad <= in_bad;
      s1_a   <= ADDR_W'(in_data.start_node);
      s1_b   <= ADDR_W'(in_data.end_node);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (node_we) begin
      fw_valid <= 1'b1;
    end
    if (node_we) begin
      fw_a   <= s1_a;
      fw_b   <= s1_b;
      fw_bit <= pick_bit;
    end
  end

  gec_count_ram #(
    .DEPTH  (COLOR_COUNT),
    .ADDR_W (IDX_W)
  ) u_count_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s1_fire),
    .rd_addr (pick_idx),
    .rd_data (cnt_rd),
    .we      (count_we),
    .wr_addr (s2_color),
    .wr_data (cnt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv1) begin
      s2_valid <= s1_valid;
    end
    if (s1_fire) begin
      s2_ovf   <= s1_ovf;
      s2_color <= pick_idx;
    end
  end

  assign cnt_cur  = (cfw_valid && cfw_addr == s2_color) ? cfw_data : cnt_rd;
  assign cnt_next = cnt_cur + COUNT_W'(1);
  assign rank     = (cnt_cur > RANK_TOP) ? '1 : cnt_cur[RANK_W-1:0];
  assign count_we = s2_fire && !s2_ovf && (cnt_cur < LIMIT_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfw_valid <= 1'b0;
    end else if (count_we) begin
      cfw_valid <= 1'b1;
    end
    if (count_we) begin
      cfw_addr <= s2_color;
      cfw_data <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= s2_valid;
    end
    if (s2_fire) begin
      out_data.color         <= s2_ovf ? '0 : COLOR_FIELD_W'(s2_color);
      out_data.rank_in_color <= s2_ovf ? '0 : rank;
      out_data.overflow      <= s2_ovf;
    end
  end

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !in_ready)
    else $error("edge accepted during mask clear");

  a_pick_is_free: assert property (
    @(posedge clk) disable iff (rst)
    node_we |-> ($onehot(pick_bit) && (((used_a | used_b) & pick_bit) == '0)))
    else $error("picked color already used at an endpoint");

  a_stage_advance: assert property (
    @(posedge clk) disable iff (rst) s1_fire |=> s2_valid)
    else $error("edge lost between stage 1 and stage 2");

  a_overflow_zero: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && out_data.overflow) |->
      (out_data.color == '0 && out_data.rank_in_color == '0))
    else $error("overflow result carries nonzero color or rank");

endmodule
